[src/lcw_pkg.sv]
// Shared types, codes, tables and helper functions of the LED color waveform generator.
package lcw_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int MAX_CHANNELS   = 3;
    localparam int EC_W           = 24;
    localparam int CH_W           = 16;
    localparam int DVD_W          = 32;

    localparam logic [1:0] KIND_SQUARE   = 2'd0;
    localparam logic [1:0] KIND_RAMP     = 2'd1;
    localparam logic [1:0] KIND_SINE     = 2'd2;
    localparam logic [1:0] KIND_TRIANGLE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;

    localparam logic [2:0] CFG_KIND      = 3'd0;
    localparam logic [2:0] CFG_COLOR     = 3'd1;
    localparam logic [2:0] CFG_CHANNELS  = 3'd2;
    localparam logic [2:0] CFG_LOG       = 3'd3;
    localparam logic [2:0] CFG_INTENSITY = 3'd4;
    localparam logic [2:0] CFG_UPPER     = 3'd5;
    localparam logic [2:0] CFG_DUTY      = 3'd6;
    localparam logic [2:0] CFG_COUNT     = 3'd7;

    localparam logic [6:0] PERCENT_MAX = 7'd100;

    typedef logic [15:0] t_tab [0:32];

    localparam t_tab LOG_TAB = '{
        16'd0, 16'd58, 16'd125, 16'd203, 16'd294, 16'd402, 16'd528, 16'd676,
        16'd850, 16'd1057, 16'd1300, 16'd1589, 16'd1930, 16'd2334, 16'd2813, 16'd3381,
        16'd4055, 16'd4856, 16'd5806, 16'd6934, 16'd8274, 16'd9866, 16'd11758, 16'd14006,
        16'd16678, 16'd19854, 16'd23630, 16'd28118, 16'd33454, 16'd39798, 16'd47340,
        16'd56309, 16'd65535
    };

    localparam t_tab SIN_TAB = '{
        16'd0, 16'd3228, 16'd6449, 16'd9653, 16'd12835, 16'd15985, 16'd19096, 16'd22161,
        16'd25172, 16'd28122, 16'd31004, 16'd33811, 16'd36535, 16'd39171, 16'd41711,
        16'd44151, 16'd46483, 16'd48702, 16'd50803, 16'd52781, 16'd54630, 16'd56347,
        16'd57927, 16'd59366, 16'd60662, 16'd61810, 16'd62808, 16'd63653, 16'd64344,
        16'd64878, 16'd65255, 16'd65474, 16'd65535
    };

    // channels the palette color requires
    function automatic logic [1:0] f_need(input logic [2:0] color);
        logic [1:0] r;
        case (color)
            3'd0, 3'd1: r = 2'd1;
            3'd2, 3'd4: r = 2'd2;
            default:    r = 2'd3;
        endcase
        return r;
    endfunction

    // bit i set where palette channel i is full scale
    function automatic logic [2:0] f_mask(input logic [2:0] color);
        logic [2:0] r;
        case (color)
            3'd1:    r = 3'b001;
            3'd2:    r = 3'b010;
            3'd3:    r = 3'b100;
            3'd4:    r = 3'b011;
            3'd5:    r = 3'b110;
            3'd6:    r = 3'b101;
            3'd7:    r = 3'b111;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] f_interp(input t_tab tab, input logic [7:0] x);
        logic [15:0] a;
        logic [15:0] b;
        logic [18:0] d;
        a = tab[x[7:3]];
        b = tab[6'(x[7:3]) + 6'd1];
        d = 19'(b - a) * 19'(x[2:0]);
        return a + 16'(d >> 3);
    endfunction

    function automatic logic [15:0] f_log(input logic [7:0] x);
        logic [15:0] r;
        if (x == 8'd0) begin
            r = 16'd0;
        end else if (x == 8'd255) begin
            r = 16'hFFFF;
        end else begin
            r = f_interp(LOG_TAB, x);
        end
        return r;
    endfunction

endpackage

[src/led_color_waveform_generator.sv]
// Top level of the LED color waveform generator.
// One word in gives one word out. A word with invalid settings or after the pattern
// has finished is answered in the cycle after acceptance; a sample word is formed by the
// shared bit-serial divider in two divisions (peak scaling, then the position or square
// threshold division), followed by the level lookup, multiply and correction steps.
// One word is in work at a time; the next is taken once the result has been delivered.
module led_color_waveform_generator
    import lcw_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] chan0_value, [31:16] chan1_value, [47:32] chan2_value
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PEAK = 7'b0000010,
        S_SEC  = 7'b0000100,
        S_LVL  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_FIX  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state;

    logic [1:0]            r_kind;
    logic [2:0]            r_color;
    logic [1:0]            r_chans;
    logic                  r_log;
    logic [6:0]            r_inten;
    logic [15:0]           r_upper;
    logic [6:0]            r_duty;
    logic [EC_W-1:0]       r_count;

    logic [COUNT_BITS-1:0] r_idx;
    logic [1:0]            r_part;
    logic                  r_fin;

    logic [EC_W-1:0]       r_plen;
    logic [2:0]            r_parts;
    logic [15:0]           r_peak;
    logic [DVD_W-1:0]      r_quo;
    logic [15:0]           r_m;
    logic [31:0]           r_prod;

    logic                  r_div_start;
    logic [DVD_W-1:0]      r_div_n;
    logic [EC_W-1:0]       r_div_d;
    logic                  w_div_done;
    logic [DVD_W-1:0]      w_div_q;

    logic                  r_ovalid;
    logic [47:0]           r_odata;
    logic [1:0]            r_ouser;
    logic                  r_olast;

    logic                  w_acc;
    logic [COUNT_BITS-1:0] w_idx;
    logic [1:0]            w_part;
    logic                  w_fin;
    logic                  w_valid;
    logic [EC_W-1:0]       w_plen;
    logic [2:0]            w_parts;
    logic                  w_empty;

    logic [7:0]            w_q8;
    logic [7:0]            w_lvl;
    logic [7:0]            w_sidx;
    logic [15:0]           w_sin;
    logic [15:0]           w_sv;
    logic [15:0]           w_m;

    logic [32:0]           w_fix;
    logic [15:0]           w_on;
    logic [15:0]           w_off;
    logic [2:0]            w_mask;
    logic [15:0]           w_ch [0:2];
    logic [COUNT_BITS:0]   w_idx_inc;
    logic [2:0]            w_part_inc;
    logic                  w_wrap;

    lcw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_n),
        .i_divisor  (r_div_d),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_idx  = s_axis_tdata[0] ? '0 : r_idx;
        w_part = s_axis_tdata[0] ? 2'd0 : r_part;
        w_fin  = s_axis_tdata[0] ? 1'b0 : r_fin;
        w_valid = (r_chans != 2'd0) && (32'(r_chans) <= 32'(MAX_CHANNELS))
               && (r_chans >= f_need(r_color))
               && !((r_kind == KIND_SQUARE) && (r_duty > PERCENT_MAX))
               && (r_inten <= PERCENT_MAX)
               && ((32'(r_count) >> COUNT_BITS) == 32'd0);
        unique case (r_kind)
            KIND_SINE: begin
                w_plen  = r_count >> 2;
                w_parts = 3'd4;
            end
            KIND_TRIANGLE: begin
                w_plen  = r_count >> 1;
                w_parts = 3'd2;
            end
            default: begin
                w_plen  = r_count;
                w_parts = 3'd1;
            end
        endcase
        w_empty = (w_plen == '0) || (3'(w_part) >= w_parts) || (EC_W'(w_idx) >= w_plen);
    end

    always_comb begin
        w_q8   = r_quo[7:0];
        w_sidx = r_part[0] ? 8'd255 - w_q8 : w_q8;
        w_sin  = f_interp(SIN_TAB, w_sidx);
        w_sv   = r_part[1] ? 16'd32768 - (w_sin >> 1) : 16'd32768 + (w_sin >> 1);
        case (r_kind)
            KIND_SQUARE:   w_lvl = (DVD_W'(r_idx) < r_quo) ? 8'd255 : 8'd0;
            KIND_TRIANGLE: w_lvl = (r_part == 2'd1) ? 8'd255 - w_q8 : w_q8;
            default:       w_lvl = w_q8;
        endcase
        if (r_kind == KIND_SINE) begin
            w_m = r_log ? f_log(w_sv[15:8]) : w_sv;
        end else begin
            w_m = r_log ? f_log(w_lvl) : {w_lvl, w_lvl};
        end
    end

    always_comb begin
        w_fix  = 33'(r_prod) + 33'(r_prod >> 16) + 33'd1;
        w_on   = w_fix[31:16];
        w_off  = ((r_kind == KIND_TRIANGLE) && (r_part == 2'd1)) ? r_peak : 16'd0;
        w_mask = f_mask(r_color);
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < r_chans) begin
                w_ch[i] = w_mask[i] ? w_on : w_off;
            end else begin
                w_ch[i] = 16'd0;
            end
        end
        w_idx_inc  = (COUNT_BITS + 1)'(r_idx) + 1'b1;
        w_part_inc = 3'(r_part) + 3'd1;
        w_wrap     = (32'(w_idx_inc) >= 32'(r_plen));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_SQUARE;
            r_color <= 3'd0;
            r_chans <= 2'd1;
            r_log   <= 1'b0;
            r_inten <= 7'd100;
            r_upper <= 16'hFFFF;
            r_duty  <= 7'd50;
            r_count <= EC_W'(256);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KIND:      r_kind  <= i_cfg_data[1:0];
                CFG_COLOR:     r_color <= i_cfg_data[2:0];
                CFG_CHANNELS:  r_chans <= i_cfg_data[1:0];
                CFG_LOG:       r_log   <= i_cfg_data[0];
                CFG_INTENSITY: r_inten <= i_cfg_data[6:0];
                CFG_UPPER:     r_upper <= i_cfg_data[15:0];
                CFG_DUTY:      r_duty  <= i_cfg_data[6:0];
                CFG_COUNT:     r_count <= i_cfg_data;
                default:       r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_part      <= 2'd0;
            r_fin       <= 1'b0;
            r_div_start <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_idx   <= w_idx;
                        r_part  <= w_part;
                        r_plen  <= w_plen;
                        r_parts <= w_parts;
                        r_odata <= '0;
                        r_olast <= 1'b0;
                        if (!w_valid) begin
                            r_fin    <= w_fin;
                            r_ouser  <= ST_INVALID;
                            r_ovalid <= 1'b1;
                            r_state  <= S_OUT;
                        end else if (w_fin || w_empty) begin
                            r_fin    <= 1'b1;
                            r_ouser  <= ST_DONE;
                            r_ovalid <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_fin       <= 1'b0;
                            r_div_start <= 1'b1;
                            r_div_n     <= DVD_W'(r_upper) * DVD_W'(r_inten);
                            r_div_d     <= EC_W'(100);
                            r_state     <= S_PEAK;
                        end
                    end
                end
                S_PEAK: begin
                    if (w_div_done) begin
                        r_peak      <= w_div_q[15:0];
                        r_div_start <= 1'b1;
                        if (r_kind == KIND_SQUARE) begin
                            r_div_n <= DVD_W'(r_count) * DVD_W'(r_duty);
                            r_div_d <= EC_W'(100);
                        end else begin
                            r_div_n <= (DVD_W'(r_idx) << 8) - DVD_W'(r_idx);
                            r_div_d <= r_plen;
                        end
                        r_state <= S_SEC;
                    end
                end
                S_SEC: begin
                    if (w_div_done) begin
                        r_quo   <= w_div_q;
                        r_state <= S_LVL;
                    end
                end
                S_LVL: begin
                    r_m     <= w_m;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= 32'(r_peak) * 32'(r_m);
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    r_odata  <= {w_ch[2], w_ch[1], w_ch[0]};
                    r_ouser  <= ST_OK;
                    r_ovalid <= 1'b1;
                    r_olast  <= 1'b0;
                    if (w_wrap) begin
                        r_idx <= '0;
                        if (w_part_inc >= r_parts) begin
                            r_part  <= 2'd0;
                            r_fin   <= 1'b1;
                            r_olast <= 1'b1;
                        end else begin
                            r_part <= w_part_inc[1:0];
                        end
                    end else begin
                        r_idx <= w_idx_inc[COUNT_BITS-1:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

`ifndef NO_ASSERTIONS
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_state == S_OUT))
        else $error("result shown outside output state");
    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == ST_OK && r_fin))
        else $error("last on a non-sample word or without finishing");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0 && !m_axis_tlast))
        else $error("error word carries data");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_PEAK || r_state == S_SEC))
        else $error("divider finished outside a division state");
`endif

endmodule

[src/lcw_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module lcw_div
    import lcw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DVD_W-1:0]   i_dividend,
    input  logic [EC_W-1:0]    i_divisor,
    output logic               o_done,
    output logic [DVD_W-1:0]   o_quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0]         r_quo;
    logic [EC_W-1:0]          r_rem;
    logic [EC_W-1:0]          r_dvs;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic [EC_W:0]            w_trial;
    logic                     w_bit;

    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_bit   = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(DVD_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], w_bit};
            r_rem <= w_bit ? EC_W'(w_trial - {1'b0, r_dvs}) : w_trial[EC_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
